// ===== rtl/spb_pkg.sv =====
// Shared types and constants of the sprite pixel blend unit.
`default_nettype none

package spb_pkg;

	localparam int COORD_W    = 10;
	localparam int CHAN_W     = 8;
	localparam int OFFSET_W   = 12;
	localparam int DEST_W     = 13;
	localparam int MODE_W     = 3;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W = 12;
	localparam int PROD_W     = 2 * CHAN_W;

	localparam logic [CHAN_W-1:0] CHAN_FULL = {CHAN_W{1'b1}};

	typedef enum logic [MODE_W-1:0] {
		MODE_COPY       = 3'd0,
		MODE_CUTOUT     = 3'd1,
		MODE_ALPHA      = 3'd2,
		MODE_ADD        = 3'd3,
		MODE_MULTIPLY   = 3'd4,
		MODE_LUMINOSITY = 3'd5
	} mode_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_BLEND_MODE = 2'd0,
		REG_OFFSET_X   = 2'd1,
		REG_OFFSET_Y   = 2'd2
	} cfg_reg_t;

endpackage

`default_nettype wire

// ===== rtl/spb_if.sv =====
// Pixel item and result channel interfaces of the sprite pixel blend unit.
`default_nettype none

interface spb_item_if;
	logic                          valid;
	logic                          ready;
	logic [spb_pkg::COORD_W-1:0]   src_x;
	logic [spb_pkg::COORD_W-1:0]   src_y;
	logic [spb_pkg::CHAN_W-1:0]    src_a;
	logic [spb_pkg::CHAN_W-1:0]    src_r;
	logic [spb_pkg::CHAN_W-1:0]    src_g;
	logic [spb_pkg::CHAN_W-1:0]    src_b;
	logic [spb_pkg::CHAN_W-1:0]    dst_r;
	logic [spb_pkg::CHAN_W-1:0]    dst_g;
	logic [spb_pkg::CHAN_W-1:0]    dst_b;

	modport source (
		output valid, src_x, src_y, src_a, src_r, src_g, src_b, dst_r, dst_g, dst_b,
		input  ready
	);
	modport sink (
		input  valid, src_x, src_y, src_a, src_r, src_g, src_b, dst_r, dst_g, dst_b,
		output ready
	);
endinterface

interface spb_result_if;
	logic                               valid;
	logic                               ready;
	logic signed [spb_pkg::DEST_W-1:0]  dest_x;
	logic signed [spb_pkg::DEST_W-1:0]  dest_y;
	logic [spb_pkg::CHAN_W-1:0]         out_a;
	logic [spb_pkg::CHAN_W-1:0]         out_r;
	logic [spb_pkg::CHAN_W-1:0]         out_g;
	logic [spb_pkg::CHAN_W-1:0]         out_b;
	logic                               write_enable;

	modport source (
		output valid, dest_x, dest_y, out_a, out_r, out_g, out_b, write_enable,
		input  ready
	);
	modport sink (
		input  valid, dest_x, dest_y, out_a, out_r, out_g, out_b, write_enable,
		output ready
	);
endinterface

`default_nettype wire

// ===== rtl/sprite_pixel_blend_unit_core.sv =====
// Top level of the sprite pixel blend unit: input stage, blend logic, result stage.
// An item passes through one input register and one result register before its result is valid.
// Throughput: one pixel per cycle while the result side is ready; a full result register still lets one item enter.
// The input stage also fills while the result stalls, so a stalled result holds one more item behind it.
// Reset clears both stage valids, selects copy mode and zeroes both offsets.
`default_nettype none

module sprite_pixel_blend_unit_core #(
	parameter int SPRITE_DIM_MAX = 1024
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                cfg_we,
	input  wire [spb_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  wire [spb_pkg::CFG_DATA_W-1:0]      cfg_wdata,
	spb_item_if.sink                           item,
	spb_result_if.source                       result
);

	localparam int RecipShift = spb_pkg::COORD_W;
	localparam int EstW       = 2 * spb_pkg::COORD_W;
	localparam logic [spb_pkg::COORD_W-1:0] Recip =
		spb_pkg::COORD_W'((1 << RecipShift) / SPRITE_DIM_MAX);

	// Configuration registers
	spb_pkg::mode_t                     mode_q;
	logic signed [spb_pkg::OFFSET_W-1:0] offset_x_q;
	logic signed [spb_pkg::OFFSET_W-1:0] offset_y_q;
	spb_pkg::mode_t                     mode_raw;
	spb_pkg::mode_t                     mode_dec;

	// Input stage
	logic                         valid_s1;
	logic [spb_pkg::COORD_W-1:0]  x_s1;
	logic [spb_pkg::COORD_W-1:0]  y_s1;
	logic [spb_pkg::COORD_W-1:0]  qx_s1;
	logic [spb_pkg::COORD_W-1:0]  qy_s1;
	logic [spb_pkg::CHAN_W-1:0]   a_s1;
	logic [spb_pkg::CHAN_W-1:0]   sr_s1;
	logic [spb_pkg::CHAN_W-1:0]   sg_s1;
	logic [spb_pkg::CHAN_W-1:0]   sb_s1;
	logic [spb_pkg::CHAN_W-1:0]   dr_s1;
	logic [spb_pkg::CHAN_W-1:0]   dg_s1;
	logic [spb_pkg::CHAN_W-1:0]   db_s1;

	// Result stage
	logic                              valid_s2;
	logic signed [spb_pkg::DEST_W-1:0] dest_x_s2;
	logic signed [spb_pkg::DEST_W-1:0] dest_y_s2;
	logic [spb_pkg::CHAN_W-1:0]        out_a_s2;
	logic [spb_pkg::CHAN_W-1:0]        out_r_s2;
	logic [spb_pkg::CHAN_W-1:0]        out_g_s2;
	logic [spb_pkg::CHAN_W-1:0]        out_b_s2;
	logic                              we_s2;

	logic                              in_xfer;
	logic                              adv;
	logic [EstW-1:0]                   est_x;
	logic [EstW-1:0]                   est_y;
	logic signed [spb_pkg::DEST_W-1:0] dest_x;
	logic signed [spb_pkg::DEST_W-1:0] dest_y;
	logic [spb_pkg::CHAN_W-1:0]        mix_r;
	logic [spb_pkg::CHAN_W-1:0]        mix_g;
	logic [spb_pkg::CHAN_W-1:0]        mix_b;
	logic                              keeps_alpha;

	// Map unused mode codes to copy
	assign mode_raw = spb_pkg::mode_t'(cfg_wdata[spb_pkg::MODE_W-1:0]);
	always_comb begin
		unique case (mode_raw) inside
			spb_pkg::MODE_COPY, spb_pkg::MODE_CUTOUT, spb_pkg::MODE_ALPHA,
			spb_pkg::MODE_ADD, spb_pkg::MODE_MULTIPLY, spb_pkg::MODE_LUMINOSITY:
				mode_dec = mode_raw;
			default: mode_dec = spb_pkg::MODE_COPY;
		endcase
	end

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= spb_pkg::MODE_COPY;
			offset_x_q <= '0;
			offset_y_q <= '0;
		end else if (cfg_we) begin
			unique case (spb_pkg::cfg_reg_t'(cfg_index))
				spb_pkg::REG_BLEND_MODE: mode_q <= mode_dec;
				spb_pkg::REG_OFFSET_X:   offset_x_q <= $signed(cfg_wdata[spb_pkg::OFFSET_W-1:0]);
				spb_pkg::REG_OFFSET_Y:   offset_y_q <= $signed(cfg_wdata[spb_pkg::OFFSET_W-1:0]);
				default: ;
			endcase
		end
	end

	// Handshake: both stages advance when the result register is free or drains; an empty input stage also accepts
	assign adv        = !valid_s2 || result.ready;
	assign item.ready = !valid_s1 || adv;
	assign in_xfer    = item.valid && item.ready;

	// Quotient estimate of the coordinate wrap, registered before the remainder
	assign est_x = ({{spb_pkg::COORD_W{1'b0}}, item.src_x} * {{spb_pkg::COORD_W{1'b0}}, Recip})
		>> RecipShift;
	assign est_y = ({{spb_pkg::COORD_W{1'b0}}, item.src_y} * {{spb_pkg::COORD_W{1'b0}}, Recip})
		>> RecipShift;

	// Hold stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (item.ready) begin
				valid_s1 <= item.valid;
			end
			if (adv) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// Capture the input item
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			x_s1  <= item.src_x;
			y_s1  <= item.src_y;
			qx_s1 <= est_x[spb_pkg::COORD_W-1:0];
			qy_s1 <= est_y[spb_pkg::COORD_W-1:0];
			a_s1  <= item.src_a;
			sr_s1 <= item.src_r;
			sg_s1 <= item.src_g;
			sb_s1 <= item.src_b;
			dr_s1 <= item.dst_r;
			dg_s1 <= item.dst_g;
			db_s1 <= item.dst_b;
		end
	end

	spb_place #(.SPRITE_DIM_MAX(SPRITE_DIM_MAX)) u_place_x (
		.coord   (x_s1),
		.quo_est (qx_s1),
		.offset  (offset_x_q),
		.dest    (dest_x)
	);

	spb_place #(.SPRITE_DIM_MAX(SPRITE_DIM_MAX)) u_place_y (
		.coord   (y_s1),
		.quo_est (qy_s1),
		.offset  (offset_y_q),
		.dest    (dest_y)
	);

	spb_mix u_mix_r (.mode(mode_q), .s(sr_s1), .d(dr_s1), .a(a_s1), .res(mix_r));
	spb_mix u_mix_g (.mode(mode_q), .s(sg_s1), .d(dg_s1), .a(a_s1), .res(mix_g));
	spb_mix u_mix_b (.mode(mode_q), .s(sb_s1), .d(db_s1), .a(a_s1), .res(mix_b));

	assign keeps_alpha = (mode_q == spb_pkg::MODE_COPY) || (mode_q == spb_pkg::MODE_CUTOUT);

	// Load the result register
	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			dest_x_s2 <= dest_x;
			dest_y_s2 <= dest_y;
			out_a_s2  <= keeps_alpha ? a_s1 : spb_pkg::CHAN_FULL;
			out_r_s2  <= mix_r;
			out_g_s2  <= mix_g;
			out_b_s2  <= mix_b;
			we_s2     <= !((mode_q == spb_pkg::MODE_CUTOUT) && (a_s1 == '0));
		end
	end

	assign result.valid        = valid_s2;
	assign result.dest_x       = dest_x_s2;
	assign result.dest_y       = dest_y_s2;
	assign result.out_a        = out_a_s2;
	assign result.out_r        = out_r_s2;
	assign result.out_g        = out_g_s2;
	assign result.out_b        = out_b_s2;
	assign result.write_enable = we_s2;

endmodule

`default_nettype wire

// ===== rtl/spb_mix.sv =====
// One color channel of the blend: copy, saturating add and the divide-by-255 blends.
`default_nettype none

module spb_mix (
	input  var spb_pkg::mode_t           mode,
	input  wire [spb_pkg::CHAN_W-1:0]    s,
	input  wire [spb_pkg::CHAN_W-1:0]    d,
	input  wire [spb_pkg::CHAN_W-1:0]    a,
	output logic [spb_pkg::CHAN_W-1:0]   res
);

	logic [spb_pkg::CHAN_W-1:0] m0;
	logic [spb_pkg::CHAN_W-1:0] m1;
	logic [spb_pkg::PROD_W-1:0] p0;
	logic [spb_pkg::PROD_W-1:0] p1;
	logic [spb_pkg::PROD_W-1:0] sum;
	logic [spb_pkg::PROD_W-1:0] quo_t;
	logic [spb_pkg::CHAN_W-1:0] quo;
	logic [spb_pkg::CHAN_W:0]   add9;
	logic [spb_pkg::CHAN_W-1:0] sat;

	// Pick multiplier operands: both products feed one shared sum
	always_comb begin
		case (mode)
			spb_pkg::MODE_ALPHA: begin
				m0 = a;
				m1 = ~a;
			end
			spb_pkg::MODE_MULTIPLY: begin
				m0 = d;
				m1 = '0;
			end
			default: begin
				m0 = s;
				m1 = ~s;
			end
		endcase
	end

	assign p0  = {{spb_pkg::CHAN_W{1'b0}}, s} * {{spb_pkg::CHAN_W{1'b0}}, m0};
	assign p1  = {{spb_pkg::CHAN_W{1'b0}}, d} * {{spb_pkg::CHAN_W{1'b0}}, m1};
	assign sum = p0 + p1;

	// Divide by 255 with truncation, exact for sums up to 255*255
	assign quo_t = sum + {{spb_pkg::CHAN_W{1'b0}}, sum[spb_pkg::PROD_W-1:spb_pkg::CHAN_W]}
		+ {{(spb_pkg::PROD_W-1){1'b0}}, 1'b1};
	assign quo   = quo_t[spb_pkg::PROD_W-1:spb_pkg::CHAN_W];

	// Clamp the add at full scale
	assign add9 = {1'b0, s} + {1'b0, d};
	assign sat  = add9[spb_pkg::CHAN_W] ? spb_pkg::CHAN_FULL : add9[spb_pkg::CHAN_W-1:0];

	// Select the channel result
	always_comb begin
		case (mode) inside
			spb_pkg::MODE_ALPHA, spb_pkg::MODE_MULTIPLY, spb_pkg::MODE_LUMINOSITY: res = quo;
			spb_pkg::MODE_ADD: res = sat;
			default: res = s;
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/spb_place.sv =====
// Coordinate wrap to the sprite size and placement at the viewport offset.
`default_nettype none

module spb_place #(
	parameter int SPRITE_DIM_MAX = 1024
) (
	input  wire [spb_pkg::COORD_W-1:0]         coord,
	input  wire [spb_pkg::COORD_W-1:0]         quo_est,
	input  wire signed [spb_pkg::OFFSET_W-1:0] offset,
	output logic signed [spb_pkg::DEST_W-1:0]  dest
);

	localparam int DimW  = $clog2(SPRITE_DIM_MAX + 1);
	localparam int ProdW = spb_pkg::COORD_W + DimW;
	localparam logic [ProdW-1:0] Dim = ProdW'(SPRITE_DIM_MAX);

	logic [ProdW-1:0]            prod;
	logic [ProdW-1:0]            diff;
	logic [ProdW-1:0]            rem_w;
	logic [spb_pkg::COORD_W-1:0] rem;

	// Remainder from the low quotient estimate; it is short by at most one
	assign prod  = {{DimW{1'b0}}, quo_est} * Dim;
	assign diff  = {{DimW{1'b0}}, coord} - prod;
	assign rem_w = (diff >= Dim) ? diff - Dim : diff;
	assign rem   = rem_w[spb_pkg::COORD_W-1:0];

	// Add the sign-extended offset
	assign dest = $signed({{(spb_pkg::DEST_W-spb_pkg::COORD_W){1'b0}}, rem})
		+ $signed({{(spb_pkg::DEST_W-spb_pkg::OFFSET_W){offset[spb_pkg::OFFSET_W-1]}}, offset});

endmodule

`default_nettype wire

// ===== rtl/spb_checker.sv =====
// Port-level checks of the sprite pixel blend unit and their binding to the top level.
`default_nettype none

module spb_checker (
	input wire                           clk,
	input wire                           arst_n,
	input wire                           in_valid,
	input wire                           in_ready,
	input wire                           out_valid,
	input wire                           out_ready,
	input wire [spb_pkg::CHAN_W-1:0]     out_a,
	input wire                           write_enable
);

	// An empty result register always leaves the input open
	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled while no result is pending");

	// A transferred item reaches the result register once the result side moves
	a_item_advances: assert property (@(posedge clk) disable iff (!arst_n)
		$past(arst_n) && $past(in_valid && in_ready) && (!out_valid || out_ready)
		|=> out_valid)
		else $error("accepted item did not advance to the result");

	// Hold a stalled result
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_a) && $stable(write_enable))
		else $error("stalled result changed");

	// A suppressed write only comes from a transparent cutout pixel
	a_cutout_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !write_enable |-> out_a == '0)
		else $error("write suppressed with nonzero alpha");

endmodule

bind sprite_pixel_blend_unit_core spb_checker u_spb_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (item.valid),
	.in_ready     (item.ready),
	.out_valid    (result.valid),
	.out_ready    (result.ready),
	.out_a        (result.out_a),
	.write_enable (result.write_enable)
);

`default_nettype wire
